[design/dcc_pkg.sv]
// ----------------------------------------------------------------------------
// dcc_pkg: shared types for the distinct color collector
// Request codes and the token that travels down the row of compare cells.
// ----------------------------------------------------------------------------
package dcc_pkg;

    // Request codes
    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_PIXEL = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_type_t;

    localparam int COLOR_W = 24;
    localparam int RIDX_W  = 8;

    // Token handed from cell to cell; the entry index travels beside it
    typedef struct packed {
        logic               vld;
        req_type_t          kind;
        logic [COLOR_W-1:0] color;
        logic [RIDX_W-1:0]  ridx;
        logic               hit;
        logic               added;
        logic [COLOR_W-1:0] rgb;
    } dcc_tok_t;

endpackage

[design/distinct_color_collector.sv]
// ----------------------------------------------------------------------------
// distinct_color_collector: palette extraction over a pixel stream
// A row of MAX_COLORS cells holds the table; each request walks the row one
// cell per cycle while the row advances, and the tail keeps the color count and overflow flag.
// ----------------------------------------------------------------------------
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------
//   request | req_valid/req_ready  | req_type, pix_*, read_index
//   result  | rsp_valid/rsp_ready  | is_new .. table_overflow
//
// A result passes through every cell register of the row and then the result
// register; the first cell loads at the accepting edge.
// A new request enters every cycle while the row advances; requests follow each other down the row.
// A result not taken stalls the whole row, and req_ready drops with it.
// Reset clears the valid flags of all cells at once; no clearing pass.
// ----------------------------------------------------------------------------
module distinct_color_collector
    import dcc_pkg::*;
#(
    parameter int MAX_COLORS = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic [1:0] req_type,
    input  logic [7:0] pix_red,
    input  logic [7:0] pix_green,
    input  logic [7:0] pix_blue,
    input  logic [7:0] read_index,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output logic       is_new,
    output logic       was_found,
    output logic [7:0] entry_index,
    output logic [7:0] entry_red,
    output logic [7:0] entry_green,
    output logic [7:0] entry_blue,
    output logic [8:0] color_total,
    output logic       table_overflow
);

    localparam int IDX_W = $clog2(MAX_COLORS);
    localparam int CNT_W = $clog2(MAX_COLORS + 1);

    dcc_tok_t         tok   [0:MAX_COLORS];
    logic [IDX_W-1:0] idx   [0:MAX_COLORS];
    logic             advance;
    dcc_tok_t         tail;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             rsp_valid_reg;
    logic             is_new_reg, is_new_next;
    logic             found_reg, found_next;
    logic [7:0]       eidx_reg, eidx_next;
    logic [23:0]      rgb_reg, rgb_next;

    // Whole row moves when the result register is free or its result is being taken
    assign advance   = !rsp_valid_reg || rsp_ready;
    assign req_ready = advance;

    // Token entering the row
    always_comb
    begin
        tok[0].vld   = req_valid;
        tok[0].kind  = req_type_t'(req_type);
        tok[0].color = {pix_red, pix_green, pix_blue};
        tok[0].ridx  = read_index;
        tok[0].hit   = 1'b0;
        tok[0].added = 1'b0;
        tok[0].rgb   = '0;
        idx[0]       = '0;
    end

    // Row of compare cells
    for (genvar g = 0; g < MAX_COLORS; g++)
    begin : g_cell
        dcc_cell #(
            .IDX_W   (IDX_W),
            .CELL_ID (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .tok_in  (tok[g]),
            .idx_in  (idx[g]),
            .tok_out (tok[g+1]),
            .idx_out (idx[g+1])
        );
    end

    assign tail = tok[MAX_COLORS];

    // Tail: count, overflow and result fields
    always_comb
    begin
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        is_new_next = 1'b0;
        found_next  = 1'b0;
        eidx_next   = '0;
        rgb_next    = '0;
        unique case (tail.kind)
            REQ_START:
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            REQ_PIXEL:
            begin
                if (tail.hit)
                begin
                    found_next = 1'b1;
                    eidx_next  = 8'(idx[MAX_COLORS]);
                end
                else if (tail.added)
                begin
                    is_new_next = 1'b1;
                    eidx_next   = 8'(idx[MAX_COLORS]);
                    count_next  = CNT_W'(count_reg + 1'b1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            REQ_READ:
            begin
                eidx_next = tail.ridx;
                rgb_next  = tail.rgb;
            end
            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= tail.vld;
            if (tail.vld)
            begin
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance && tail.vld)
        begin
            is_new_reg <= is_new_next;
            found_reg  <= found_next;
            eidx_reg   <= eidx_next;
            rgb_reg    <= rgb_next;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign is_new         = is_new_reg;
    assign was_found      = found_reg;
    assign entry_index    = eidx_reg;
    assign entry_red      = rgb_reg[23:16];
    assign entry_green    = rgb_reg[15:8];
    assign entry_blue     = rgb_reg[7:0];
    assign color_total    = 9'(count_reg);
    assign table_overflow = ovf_reg;

endmodule

[design/dcc_cell.sv]
// ----------------------------------------------------------------------------
// dcc_cell: one table entry of the color collector
// Holds one color and its valid flag, and updates the token passing through:
// match, append into the first free entry, read-out or clear.
// ----------------------------------------------------------------------------
module dcc_cell
    import dcc_pkg::*;
#(
    parameter int IDX_W   = 8,
    parameter int CELL_ID = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  dcc_tok_t         tok_in,
    input  logic [IDX_W-1:0] idx_in,
    output dcc_tok_t         tok_out,
    output logic [IDX_W-1:0] idx_out
);

    localparam int CMP_W = (IDX_W > RIDX_W) ? IDX_W : RIDX_W;

    logic               valid_reg, valid_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    dcc_tok_t           tok_reg, tok_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               ridx_match;

    assign ridx_match = (CMP_W'(tok_in.ridx) == CMP_W'(CELL_ID));

    // Token processing against the stored entry
    always_comb
    begin
        tok_next   = tok_in;
        idx_next   = idx_in;
        valid_next = valid_reg;
        color_next = color_reg;
        if (tok_in.vld)
        begin
            unique case (tok_in.kind)
                REQ_START:
                begin
                    valid_next = 1'b0;
                end
                REQ_PIXEL:
                begin
                    if (!tok_in.hit && !tok_in.added)
                    begin
                        if (valid_reg)
                        begin
                            if (color_reg == tok_in.color)
                            begin
                                tok_next.hit = 1'b1;
                                idx_next     = IDX_W'(CELL_ID);
                            end
                        end
                        else
                        begin
                            // first free entry: append here
                            tok_next.added = 1'b1;
                            idx_next       = IDX_W'(CELL_ID);
                            valid_next     = 1'b1;
                            color_next     = tok_in.color;
                        end
                    end
                end
                REQ_READ:
                begin
                    if (valid_reg && ridx_match)
                    begin
                        tok_next.rgb = color_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control state and token
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            color_reg <= color_next;
            idx_reg   <= idx_next;
        end
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

endmodule

[design/dcc_checker.sv]
// ----------------------------------------------------------------------------
// dcc_checker: port-level checks for the distinct color collector
// Watches the result channel and the relation between its fields.
// ----------------------------------------------------------------------------
module dcc_checker #(
    parameter int MAX_COLORS = 256
) (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic [1:0] req_type,
    input logic [7:0] pix_red,
    input logic [7:0] pix_green,
    input logic [7:0] pix_blue,
    input logic [7:0] read_index,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       is_new,
    input logic       was_found,
    input logic [7:0] entry_index,
    input logic [7:0] entry_red,
    input logic [7:0] entry_green,
    input logic [7:0] entry_blue,
    input logic [8:0] color_total,
    input logic       table_overflow
);

    // A pixel is either new or found, never both
    a_new_xor_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(is_new && was_found))
        else $error("is_new and was_found both set");

    // An appended color lands at the last used entry
    a_new_at_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && is_new) |-> (entry_index == 8'(color_total - 9'd1)))
        else $error("appended entry index does not match count");

    // No append while the overflow flag stands
    a_no_new_after_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && is_new) |-> !table_overflow)
        else $error("new color reported with overflow set");

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(entry_index)
                                       && $stable(color_total)))
        else $error("result changed while stalled");

endmodule

bind distinct_color_collector dcc_checker #(.MAX_COLORS(MAX_COLORS)) u_dcc_checker (.*);

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for the distinct color collector
// Streams start, pixel, read and no-op requests through the collector under random
// idling on both channels. It keeps its own palette model to work out every
// reply, and checks the replies field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
    import dcc_pkg::*;

    localparam int TABLE_DEPTH  = 256;
    localparam int RANDOM_ITEMS = 925;
    localparam int BIG_AT       = 200;

    // One request as the driver presents it
    typedef struct packed {
        req_type_t   kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  ridx;
        logic        drain;
    } palette_req_t;

    // One reply, in port order
    typedef struct packed {
        logic        is_new;
        logic        was_found;
        logic [7:0]  index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [8:0]  total;
        logic        overflow;
    } palette_rsp_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    logic [1:0] req_type = REQ_NONE;
    logic [7:0] pix_red = 8'd0;
    logic [7:0] pix_green = 8'd0;
    logic [7:0] pix_blue = 8'd0;
    logic [7:0] read_index = 8'd0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    logic       is_new;
    logic       was_found;
    logic [7:0] entry_index;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;
    logic [8:0] color_total;
    logic       table_overflow;

    distinct_color_collector #(
        .MAX_COLORS(TABLE_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_type(req_type),
        .pix_red(pix_red),
        .pix_green(pix_green),
        .pix_blue(pix_blue),
        .read_index(read_index),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .is_new(is_new),
        .was_found(was_found),
        .entry_index(entry_index),
        .entry_red(entry_red),
        .entry_green(entry_green),
        .entry_blue(entry_blue),
        .color_total(color_total),
        .table_overflow(table_overflow)
    );

    // Requests waiting to be driven, replies owed by the collector
    palette_req_t pending_reqs[$];
    palette_rsp_t palette_replies[$];

    // Palette state as the testbench sees it
    logic [23:0] pal_table [TABLE_DEPTH];
    int unsigned pal_count = 0;
    logic        pal_ovf = 1'b0;

    // Shadow of the palette while building stimulus: keeps reads legal
    bit          gen_seen [logic [23:0]];
    logic [23:0] gen_list[$];
    int unsigned gen_count = 0;
    int unsigned gen_hwm = 0;

    int          err_cnt = 0;
    int          acc_cnt = 0;
    int          chk_cnt = 0;
    int          stim_total = 0;

    palette_req_t cur_req = '0;
    palette_req_t nxt_req;
    bit           drv_fire;
    bit           drv_busy;
    int           gap_left = 0;
    int           tx_quiet = 0;
    int           stall_left = 0;
    int           rx_quiet = 0;

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_error(string msg);
        $display("ERROR: %s", msg);
        err_cnt++;
    endtask

    // Apply one request to the palette and return the reply it owes
    function automatic palette_rsp_t palette_update(palette_req_t rq);
        palette_rsp_t rs;
        logic [23:0]  color;
        int           hit_idx;
        rs = '0;
        color = {rq.red, rq.green, rq.blue};
        hit_idx = -1;
        case (rq.kind)
            REQ_START:
            begin
                pal_count = 0;
                pal_ovf = 1'b0;
            end
            REQ_PIXEL:
            begin
                for (int i = 0; i < int'(pal_count); i++)
                begin
                    if (hit_idx < 0 && pal_table[i] == color)
                        hit_idx = i;
                end
                if (hit_idx >= 0)
                begin
                    rs.was_found = 1'b1;
                    rs.index = hit_idx[7:0];
                end
                else if (pal_count < TABLE_DEPTH)
                begin
                    pal_table[pal_count] = color;
                    rs.is_new = 1'b1;
                    rs.index = pal_count[7:0];
                    pal_count++;
                end
                else
                begin
                    // full: color dropped, flag sticks until next start
                    pal_ovf = 1'b1;
                end
            end
            REQ_READ:
            begin
                rs.index = rq.ridx;
                if (rq.ridx < pal_count)
                    {rs.red, rs.green, rs.blue} = pal_table[rq.ridx];
            end
            default:
            begin
            end
        endcase
        rs.total = pal_count[8:0];
        rs.overflow = pal_ovf;
        return rs;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------
    task automatic push_req(req_type_t kind, logic [23:0] color, logic [7:0] ridx,
                            bit drain);
        palette_req_t rq;
        rq.kind = kind;
        {rq.red, rq.green, rq.blue} = color;
        rq.ridx = ridx;
        rq.drain = drain;
        pending_reqs.push_back(rq);
        if (kind == REQ_START)
        begin
            gen_seen.delete();
            gen_list.delete();
            gen_count = 0;
        end
        else if (kind == REQ_PIXEL && !gen_seen.exists(color) && gen_count < TABLE_DEPTH)
        begin
            gen_seen[color] = 1'b1;
            gen_list.push_back(color);
            gen_count++;
            if (gen_count > gen_hwm)
                gen_hwm = gen_count;
        end
    endtask

    function automatic logic [23:0] fresh_color();
        logic [23:0] c;
        c = 24'($urandom);
        while (gen_seen.exists(c))
            c = 24'($urandom);
        return c;
    endfunction

    task automatic push_pixel(logic [23:0] color);
        push_req(REQ_PIXEL, color, 8'($urandom), 1'b0);
    endtask

    // Reads only touch entries that were written at some point
    task automatic push_read();
        if (gen_hwm == 0)
            push_pixel(24'($urandom));
        else
            push_req(REQ_READ, 24'($urandom), 8'($urandom_range(0, gen_hwm - 1)), 1'b0);
    endtask

    task automatic push_repeat();
        if (gen_list.size() == 0)
            push_pixel(fresh_color());
        else
            push_pixel(gen_list[$urandom_range(0, gen_list.size() - 1)]);
    endtask

    // Image with a small palette, plus reads and some noise
    task automatic small_image(bit drain);
        logic [23:0] pal_q[$];
        int          k;
        int          n;
        int          r;
        push_req(REQ_START, 24'($urandom), 8'($urandom), drain);
        k = $urandom_range(1, 12);
        n = $urandom_range(5, 40);
        for (int i = 0; i < k; i++)
            pal_q.push_back(24'($urandom));
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                push_pixel(pal_q[$urandom_range(0, k - 1)]);
            else if (r < 78)
                push_pixel(24'($urandom));
            else if (r < 92)
                push_read();
            else if (r < 97)
                push_req(REQ_NONE, 24'($urandom), 8'($urandom), 1'b0);
            else
                push_req(REQ_START, 24'($urandom), 8'($urandom), 1'b0);
        end
    endtask

    // Image that fills the table and then runs past it
    task automatic fill_image();
        int r;
        push_req(REQ_START, 24'($urandom), 8'($urandom), 1'b1);
        while (gen_count < TABLE_DEPTH)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                push_pixel(fresh_color());
            else if (r < 90)
                push_repeat();
            else
                push_read();
        end
        push_req(REQ_READ, 24'($urandom), 8'd255, 1'b0);
        push_req(REQ_READ, 24'($urandom), 8'd0, 1'b0);
        for (int i = 0; i < 30; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                push_pixel(fresh_color());
            else if (r < 70)
                push_repeat();
            else
                push_read();
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents one request at a time, holds it until taken
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (tx_quiet > 0)
        begin
            tx_quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 10);
        else if (r < 99)
            return $urandom_range(20, 60);
        tx_quiet = $urandom_range(50, 150);
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            drv_fire = req_valid && req_ready;
            if (drv_fire)
            begin
                palette_replies.push_back(palette_update(cur_req));
                acc_cnt <= acc_cnt + 1;
                gap_left = pick_gap();
            end
            drv_busy = req_valid && !drv_fire;
            if (!drv_busy)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_reqs.size() > 0 &&
                         !(pending_reqs[0].drain && (acc_cnt + int'(drv_fire) != chk_cnt)))
                begin
                    nxt_req = pending_reqs.pop_front();
                    cur_req <= nxt_req;
                    req_type <= nxt_req.kind;
                    pix_red <= nxt_req.red;
                    pix_green <= nxt_req.green;
                    pix_blue <= nxt_req.blue;
                    read_index <= nxt_req.ridx;
                    drv_busy = 1'b1;
                end
            end
            req_valid <= drv_busy;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: takes replies and checks them against the owed ones
    // ------------------------------------------------------------------------
    function automatic int pick_stall();
        int r;
        if (rx_quiet > 0)
        begin
            rx_quiet--;
            return 0;
        end
        r = $urandom_range(0, 999);
        if (r < 850)
            return 0;
        else if (r < 960)
            return $urandom_range(1, 3);
        else if (r < 992)
            return $urandom_range(4, 12);
        else if (r < 998)
            return $urandom_range(30, 80);
        rx_quiet = $urandom_range(100, 300);
        return 0;
    endfunction

    task automatic field_check(string name, logic [8:0] got, logic [8:0] want);
        if (got !== want)
            report_error($sformatf("reply %0d %s: got %0h, expected %0h",
                                   chk_cnt, name, got, want));
    endtask

    task automatic check_reply();
        palette_rsp_t got;
        palette_rsp_t want;
        got = {is_new, was_found, entry_index, entry_red, entry_green, entry_blue,
               color_total, table_overflow};
        if (palette_replies.size() == 0)
        begin
            report_error($sformatf("reply %0d arrived with nothing owed", chk_cnt));
            return;
        end
        want = palette_replies.pop_front();
        field_check("is_new", 9'(got.is_new), 9'(want.is_new));
        field_check("was_found", 9'(got.was_found), 9'(want.was_found));
        field_check("entry_index", 9'(got.index), 9'(want.index));
        field_check("entry_red", 9'(got.red), 9'(want.red));
        field_check("entry_green", 9'(got.green), 9'(want.green));
        field_check("entry_blue", 9'(got.blue), 9'(want.blue));
        field_check("color_total", got.total, want.total);
        field_check("table_overflow", 9'(got.overflow), 9'(want.overflow));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                check_reply();
                chk_cnt <= chk_cnt + 1;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                stall_left = pick_stall();
                rsp_ready <= (stall_left == 0);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: build stimulus, reset, wait for drain, report
    // ------------------------------------------------------------------------
    initial
    begin
        bit big_done;
        int r;
        big_done = 1'b0;

        // Directed: extremes, every request code and count corners
        push_req(REQ_START, 24'h000000, 8'h00, 1'b1);
        push_req(REQ_NONE, 24'hFFFFFF, 8'hFF, 1'b0);
        push_req(REQ_PIXEL, 24'h000000, 8'h00, 1'b0);
        push_req(REQ_PIXEL, 24'hFFFFFF, 8'hFF, 1'b0);
        push_req(REQ_PIXEL, 24'h000000, 8'hAA, 1'b0);
        push_req(REQ_PIXEL, 24'hFFFFFF, 8'h55, 1'b0);
        push_req(REQ_PIXEL, 24'hAA55AA, 8'h00, 1'b0);
        push_req(REQ_PIXEL, 24'h55AA55, 8'h00, 1'b0);
        push_req(REQ_PIXEL, 24'hFF0000, 8'h00, 1'b0);
        push_req(REQ_PIXEL, 24'h00FF00, 8'h00, 1'b0);
        push_req(REQ_PIXEL, 24'h0000FF, 8'h00, 1'b0);
        push_req(REQ_READ, 24'h000000, 8'd0, 1'b0);
        push_req(REQ_READ, 24'hFFFFFF, 8'd6, 1'b0);
        push_req(REQ_READ, 24'h123456, 8'd3, 1'b0);
        push_req(REQ_NONE, 24'h000000, 8'h00, 1'b0);
        // after a start, reads past the count return no color
        push_req(REQ_START, 24'hFFFFFF, 8'hFF, 1'b0);
        push_req(REQ_READ, 24'h000000, 8'd4, 1'b0);
        push_req(REQ_READ, 24'h000000, 8'd0, 1'b0);
        push_req(REQ_PIXEL, 24'h0000FF, 8'h00, 1'b0);
        push_req(REQ_READ, 24'h000000, 8'd0, 1'b0);
        push_req(REQ_READ, 24'h000000, 8'd1, 1'b0);
        push_req(REQ_PIXEL, 24'h0000FF, 8'h00, 1'b0);
        push_req(REQ_NONE, 24'hFFFFFF, 8'hFF, 1'b0);

        // Random images; one of them fills the table and overflows
        r = pending_reqs.size();
        while (pending_reqs.size() < r + RANDOM_ITEMS)
        begin
            if (!big_done && pending_reqs.size() >= BIG_AT)
            begin
                fill_image();
                big_done = 1'b1;
            end
            else
                small_image($urandom_range(0, 5) == 0);
        end
        stim_total = pending_reqs.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (acc_cnt != stim_total || chk_cnt != acc_cnt)
            @(posedge clk);
        repeat (TABLE_DEPTH + 16) @(posedge clk);

        if (palette_replies.size() != 0)
            report_error($sformatf("%0d replies never arrived", palette_replies.size()));
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
